// ===== hw/rtl/cpu_load_percent_monitor_unit_assert.svh =====
// ----------------------------------------------------------------------------
// CPU load monitor assertion macros
// Shared forms for the concurrent checks on the monitor's ports.
// ----------------------------------------------------------------------------
`ifndef CPU_LOAD_PERCENT_MONITOR_UNIT_ASSERT_SVH
`define CPU_LOAD_PERCENT_MONITOR_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the condition.
`define CLPM_ASSERT_SAME(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// The consequent must hold in the cycle after the condition.
`define CLPM_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

// ===== hw/rtl/clpm_pkg.sv =====
// ----------------------------------------------------------------------------
// CPU load monitor package
// Widths, limits and shared types of the load monitor and its divider.
// ----------------------------------------------------------------------------
package clpm_pkg;

    // Field widths of the sample and result transactions.
    localparam int IDX_W   = 6;
    localparam int CNT_W   = 64;
    localparam int N_CNT   = 8;
    localparam int LOAD_W  = 7;
    localparam int SUM_W   = 13;
    localparam int COUNT_W = 7;

    // Index of the idle and iowait counters within a sample.
    localparam int IDLE_POS   = 3;
    localparam int IOWAIT_POS = 4;

    // Packed stream widths, padded to whole bytes.
    localparam int IN_TDATA_W  = 520;
    localparam int OUT_TDATA_W = 24;

    // Widest index a processor count can need, and the index space of a sample.
    localparam int IDX_EXT_W = 11;
    localparam int MAX_INDEX = 64;

    // Divider: seven quotient bits over a numerator of up to 71 bits.
    localparam int QUOT_W = LOAD_W;
    localparam int NUM_W  = CNT_W + QUOT_W;

    localparam logic [LOAD_W-1:0]  PCT_FULL  = 7'd100;
    localparam logic [SUM_W-1:0]   SUM_MAX   = 13'd8191;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

    // Request into the divider.
    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } t_div_req;

    // Result from the divider; done pulses for one cycle.
    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quotient;
    } t_div_rsp;

endpackage

// ===== hw/rtl/clpm_div.sv =====
// ----------------------------------------------------------------------------
// CPU load monitor divider
// Restoring divider with a seven-bit quotient, one quotient bit per cycle.
// The dividend must stay below 128 times the divisor.
// ----------------------------------------------------------------------------
module clpm_div
    import clpm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int STEP_W = $clog2(QUOT_W);

    logic [NUM_W-1:0]  r_rem;
    logic [NUM_W-1:0]  r_dsr;
    logic [QUOT_W-1:0] r_quo;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic              r_done;
    logic              fits;

    // The shifted divisor fits into the remainder at this quotient bit.
    assign fits = (r_dsr <= r_rem);

    // Control: busy while the quotient bits are worked out, then a done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(QUOT_W - 1);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: compare and subtract, then move the divisor one bit down.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.dividend;
            r_dsr <= NUM_W'({i_req.divisor, {(QUOT_W-1){1'b0}}});
            r_quo <= '0;
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= r_rem - r_dsr;
            end
            r_quo <= {r_quo[QUOT_W-2:0], fits};
            r_dsr <= r_dsr >> 1;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ===== hw/rtl/cpu_load_percent_monitor_unit.sv =====
// ----------------------------------------------------------------------------
// CPU load percent monitor
// Per-processor load percent from cumulative time counters, with the sweep
// average and peak on the last sample of each sweep.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one sample per transaction: the processor index
//   and eight 64-bit cumulative counters in tdata, and the last-of-sweep mark
//   in tlast. The master stream returns one result per sample: the load of
//   that processor in tdata, and tlast high on the result that closes a sweep,
//   which then also carries the average and peak load of the sweep.
//   The block works on one sample at a time. The eight counters of a sample
//   are summed, checked against the stored counters of its processor, and
//   divided by a shared restoring divider at one quotient bit per cycle. The
//   result is loaded into the output register as the block turns ready for
//   the next sample. On the last sample of a sweep the average needs a second
//   pass of the divider, unless the average is clamped.
//   The previous counters of each processor sit in one synchronous memory;
//   a valid bit per entry stands for its all-zero reset, so reset takes effect
//   at once with no clearing pass.
//   A result waits in the output register while the receiver stalls; the next
//   sample is still accepted and worked on, and waits before its own output
//   until that register is free.
// ----------------------------------------------------------------------------
module cpu_load_percent_monitor_unit
    import clpm_pkg::*;
#(
    parameter int MAX_CPUS = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Slave side.
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // tdata, from bit 0 up: cpu_index[5:0], user_time, nice_time, system_time,
    // idle_time, iowait_time, irq_time, softirq_time, steal_time (64 bits each),
    // two zero bits of padding.
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // tlast: last_of_sweep.
    input  logic                   i_s_axis_tlast,
    // Master side.
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // tdata, from bit 0 up: cpu_load[6:0], average_load[6:0], peak_load[6:0],
    // three zero bits of padding.
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    // tlast: sweep_done.
    output logic                   o_m_axis_tlast
);

    // Only indexes a sample can carry need an entry.
    localparam int DEPTH = (MAX_CPUS < MAX_INDEX) ? MAX_CPUS : MAX_INDEX;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [IDX_EXT_W-1:0] CPU_LIMIT = IDX_EXT_W'(MAX_CPUS);
    localparam int STEP_W = $clog2(N_CNT);

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_SUM      = 12'b0000_0000_0010,
        S_DELTA    = 12'b0000_0000_0100,
        S_CHECK    = 12'b0000_0000_1000,
        S_MUL1     = 12'b0000_0001_0000,
        S_MUL2     = 12'b0000_0010_0000,
        S_PCT_GO   = 12'b0000_0100_0000,
        S_PCT_WAIT = 12'b0000_1000_0000,
        S_ACC      = 12'b0001_0000_0000,
        S_AVG_GO   = 12'b0010_0000_0000,
        S_AVG_WAIT = 12'b0100_0000_0000,
        S_OUT      = 12'b1000_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Sample registers.
    logic [CNT_W-1:0]    r_cnt [N_CNT];
    logic [AW-1:0]       r_addr;
    logic                r_in_range;
    logic                r_hit;
    logic                r_last;
    logic [STEP_W-1:0]   r_step;

    // Working values.
    logic [CNT_W-1:0]    r_total;
    logic [CNT_W-1:0]    r_idle;
    logic [CNT_W-1:0]    r_dt;
    logic [CNT_W-1:0]    r_di;
    logic [CNT_W-1:0]    r_busy_dt;
    logic                r_first;
    logic                r_skip;
    logic [NUM_W-1:0]    r_num;
    logic [LOAD_W-1:0]   r_load;
    logic [LOAD_W-1:0]   r_avg;

    // Sweep accumulators.
    logic [SUM_W-1:0]    r_sum;
    logic [COUNT_W-1:0]  r_count;
    logic [LOAD_W-1:0]   r_peak;
    logic [SUM_W-1:0]    n_sum;
    logic [COUNT_W-1:0]  n_count;
    logic [LOAD_W-1:0]   n_peak;
    logic [SUM_W:0]      sum_wide;

    // Previous counters per processor: total in the upper half, idle below.
    logic [2*CNT_W-1:0]  r_mem [DEPTH];
    logic [2*CNT_W-1:0]  r_rd_data;
    logic [DEPTH-1:0]    r_valid;

    // Output register.
    logic                r_out_valid;
    logic [LOAD_W-1:0]   r_out_load;
    logic [LOAD_W-1:0]   r_out_avg;
    logic [LOAD_W-1:0]   r_out_peak;
    logic                r_out_last;

    logic                s_accept;
    logic                out_free;
    logic [IDX_EXT_W-1:0] in_idx;
    logic                in_range;
    logic [AW-1:0]       in_addr;
    logic [CNT_W-1:0]    mem_total;
    logic [CNT_W-1:0]    mem_idle;
    logic                avg_direct;
    t_div_req            div_req;
    t_div_rsp            div_rsp;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;

    // Index check and memory address of the incoming sample.
    assign in_idx   = IDX_EXT_W'(i_s_axis_tdata[IDX_W-1:0]);
    assign in_range = (in_idx < CPU_LIMIT);
    assign in_addr  = in_idx[AW-1:0];

    // An entry never written reads as zero.
    assign mem_total = r_hit ? r_rd_data[2*CNT_W-1:CNT_W] : '0;
    assign mem_idle  = r_hit ? r_rd_data[CNT_W-1:0] : '0;

    // Sweep accumulator update with saturation.
    assign sum_wide = {1'b0, r_sum} + (SUM_W+1)'(r_load);
    always_comb begin
        n_sum   = (sum_wide > (SUM_W+1)'(SUM_MAX)) ? SUM_MAX : sum_wide[SUM_W-1:0];
        n_count = (r_count < COUNT_MAX) ? (r_count + 1'b1) : r_count;
        n_peak  = (r_load > r_peak) ? r_load : r_peak;
    end

    // The average is clamped or zero without a division when it cannot fit.
    assign avg_direct = (r_count == '0) ||
                        ({1'b0, r_sum} >= {r_count, {(SUM_W+1-COUNT_W){1'b0}}});

    // Divider requests: the load percent first, the sweep average second.
    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = r_num;
        div_req.divisor  = r_dt;
        case (r_state)
            S_PCT_GO: begin
                div_req.start = 1'b1;
            end
            S_AVG_GO: begin
                div_req.start    = !avg_direct;
                div_req.dividend = NUM_W'(r_sum);
                div_req.divisor  = CNT_W'(r_count);
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end

    clpm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:     if (s_accept) n_state = S_SUM;
            S_SUM:      if (r_step == STEP_W'(N_CNT - 1)) n_state = S_DELTA;
            S_DELTA:    n_state = S_CHECK;
            S_CHECK:    n_state = S_MUL1;
            S_MUL1:     n_state = S_MUL2;
            S_MUL2:     n_state = S_PCT_GO;
            S_PCT_GO:   n_state = S_PCT_WAIT;
            S_PCT_WAIT: if (div_rsp.done) n_state = S_ACC;
            S_ACC:      n_state = r_last ? S_AVG_GO : S_OUT;
            S_AVG_GO:   n_state = avg_direct ? S_OUT : S_AVG_WAIT;
            S_AVG_WAIT: if (div_rsp.done) n_state = S_OUT;
            S_OUT:      if (out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // Control state: state, valid bits, sweep accumulators, output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_sum       <= '0;
            r_count     <= '0;
            r_peak      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DELTA && r_in_range) begin
                r_valid[r_addr] <= 1'b1;
            end
            if (r_state == S_ACC) begin
                r_sum   <= n_sum;
                r_count <= n_count;
                r_peak  <= n_peak;
            end
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
                if (r_last) begin
                    r_sum   <= '0;
                    r_count <= '0;
                    r_peak  <= '0;
                end
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Counter memory: read on accept, write back once the new sums are known.
    always_ff @(posedge i_clk) begin
        if (s_accept && in_range) begin
            r_rd_data <= r_mem[in_addr];
        end
        if (r_state == S_DELTA && r_in_range) begin
            r_mem[r_addr] <= {r_total, r_idle};
        end
    end

    // Datapath of one sample.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    for (int k = 0; k < N_CNT; k++) begin
                        r_cnt[k] <= i_s_axis_tdata[IDX_W + k*CNT_W +: CNT_W];
                    end
                    r_addr     <= in_addr;
                    r_in_range <= in_range;
                    r_hit      <= in_range && r_valid[in_addr];
                    r_last     <= i_s_axis_tlast;
                    r_total    <= '0;
                    r_step     <= '0;
                end
            end
            S_SUM: begin
                // One counter a cycle into the total; idle on the first pass.
                r_total <= r_total + r_cnt[r_step];
                r_step  <= r_step + 1'b1;
                if (r_step == '0) begin
                    r_idle <= r_cnt[IDLE_POS] + r_cnt[IOWAIT_POS];
                end
            end
            S_DELTA: begin
                r_first <= (mem_total == '0);
                r_dt    <= r_total - mem_total;
                r_di    <= r_idle - mem_idle;
            end
            S_CHECK: begin
                // Out of range, first sample, no elapsed time or more idle
                // than elapsed time all give a load of zero.
                r_skip    <= !r_in_range || r_first || (r_dt == '0) || (r_di > r_dt);
                r_busy_dt <= r_dt - r_di;
            end
            S_MUL1: begin
                // Busy times 100 as busy*64 + busy*4 + busy*32.
                r_num <= NUM_W'({r_busy_dt, 6'b0}) + NUM_W'({r_busy_dt, 2'b0});
            end
            S_MUL2: begin
                r_num <= r_num + NUM_W'({r_busy_dt, 5'b0});
            end
            S_PCT_WAIT: begin
                if (div_rsp.done) begin
                    r_load <= r_skip ? '0 : div_rsp.quotient;
                end
            end
            S_AVG_GO: begin
                if (avg_direct) begin
                    r_avg <= (r_count == '0) ? '0 : PCT_FULL;
                end
            end
            S_AVG_WAIT: begin
                if (div_rsp.done) begin
                    r_avg <= (div_rsp.quotient > PCT_FULL) ? PCT_FULL : div_rsp.quotient;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    r_out_load <= r_load;
                    r_out_last <= r_last;
                    r_out_avg  <= r_last ? r_avg : '0;
                    r_out_peak <= r_last ? r_peak : '0;
                end
            end
            default: begin
                r_step <= r_step;
            end
        endcase
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tdata  = OUT_TDATA_W'({r_out_peak, r_out_avg, r_out_load});

endmodule

// ===== hw/rtl/clpm_checker.sv =====
// ----------------------------------------------------------------------------
// CPU load monitor checker
// Port-level checks on the result stream and the sample handshake.
// ----------------------------------------------------------------------------
`include "cpu_load_percent_monitor_unit_assert.svh"

module clpm_checker
    import clpm_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_axis_tvalid,
    input logic                   o_s_axis_tready,
    input logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    input logic                   i_s_axis_tlast,
    input logic                   o_m_axis_tvalid,
    input logic                   i_m_axis_tready,
    input logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    input logic                   o_m_axis_tlast
);

    logic [LOAD_W-1:0] out_load;
    logic [LOAD_W-1:0] out_avg;
    logic [LOAD_W-1:0] out_peak;
    logic              s_accept;

    assign out_load = o_m_axis_tdata[LOAD_W-1:0];
    assign out_avg  = o_m_axis_tdata[2*LOAD_W-1:LOAD_W];
    assign out_peak = o_m_axis_tdata[3*LOAD_W-1:2*LOAD_W];
    assign s_accept = i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tdata == i_s_axis_tdata)
                      && (i_s_axis_tlast == i_s_axis_tlast);

    // Every percent field stays within full load.
    `CLPM_ASSERT_SAME(a_pct_range, i_clk, i_rst_n, o_m_axis_tvalid, (out_load <= PCT_FULL) && (out_avg <= PCT_FULL) && (out_peak <= PCT_FULL), "percent field above 100")

    // Sweep figures are zero on results that do not close a sweep.
    `CLPM_ASSERT_SAME(a_mid_sweep_zero, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tlast, (out_avg == '0) && (out_peak == '0), "sweep fields set mid-sweep")

    // The sweep peak includes the load of its closing sample.
    `CLPM_ASSERT_SAME(a_peak_covers, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tlast, out_peak >= out_load, "peak below closing load")

    // One sample at a time: no transaction in the cycle after one.
    `CLPM_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, s_accept, !o_s_axis_tready, "sample accepted back to back")

    // A stalled result holds.
    `CLPM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast), "stalled result changed")

endmodule

bind cpu_load_percent_monitor_unit clpm_checker u_clpm_checker (.*);
